// ===== design/edr_pkg.sv =====
// shared types and constants for the descriptor ring host
// no dependencies
package edr_pkg;

    typedef enum logic [2:0] {
        OUT_RX_EMPTY     = 3'd0,
        OUT_RX_DELIVERED = 3'd1,
        OUT_RX_DISCARDED = 3'd2,
        OUT_TX_QUEUED    = 3'd3,
        OUT_TX_REJECTED  = 3'd4,
        OUT_TX_FULL      = 3'd5
    } outcome_t;

    localparam int unsigned OWN_POS   = 15;
    localparam int unsigned ERR_POS   = 14;
    localparam int unsigned START_POS = 9;
    localparam int unsigned END_POS   = 8;

    localparam logic [15:0] RX_STATUS_WORD = 16'h8000;
    localparam logic [15:0] TX_STATUS_WORD = 16'h8300;
    localparam logic [3:0]  LENGTH_TOP     = 4'hF;
    localparam logic [11:0] CRC_BYTES      = 12'd4;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = 1;

    typedef struct packed {
        outcome_t    outcome;
        logic [11:0] frame_length;
        logic [5:0]  pad_bytes;
        logic [15:0] length_word;
        logic [15:0] status_word;
        logic        write_back;
    } cmd_t;

endpackage

// ===== design/edr_front.sv =====
// front end: takes request beats and classifies them into commands
// depends on edr_pkg
module edr_front import edr_pkg::*; #(
    parameter int unsigned BUFFER_BYTES    = 2048,
    parameter int unsigned MIN_FRAME_BYTES = 60
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_enabled,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [15:0] s_desc_status,
    input  logic [11:0] s_desc_byte_count,
    input  logic [15:0] s_send_length,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);

    localparam logic [12:0] BUF_LIMIT_RX = 13'(BUFFER_BYTES);
    localparam logic [15:0] BUF_LIMIT_TX = 16'(BUFFER_BYTES);
    localparam logic [15:0] MIN_LEN      = 16'(MIN_FRAME_BYTES);
    localparam logic [11:0] RX_NEG_LEN   = 12'(12'd0 - 12'(BUFFER_BYTES));

    logic enabled_reg, enabled_next;
    logic cmd_valid_reg, cmd_valid_next;
    cmd_t cmd_reg, cmd_next;

    logic        rx_good;
    logic        tx_bad;
    logic [15:0] tx_total;

    assign cfg_ready = 1'b1;
    assign s_ready   = !cmd_valid_reg || cmd_ready;
    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

    always_comb begin
        rx_good = s_desc_status[START_POS] && s_desc_status[END_POS]
                  && !s_desc_status[ERR_POS] && (s_desc_byte_count > CRC_BYTES)
                  && ({1'b0, s_desc_byte_count} <= BUF_LIMIT_RX);
        tx_bad  = !enabled_reg || (s_send_length == 16'd0) || (s_send_length > BUF_LIMIT_TX);
        tx_total = (s_send_length < MIN_LEN) ? MIN_LEN : s_send_length;

        cmd_next = '{outcome: OUT_RX_EMPTY, frame_length: '0, pad_bytes: '0,
                     length_word: '0, status_word: '0, write_back: 1'b0};
        if (!s_req_type) begin
            if (!s_desc_status[OWN_POS]) begin
                cmd_next.outcome     = rx_good ? OUT_RX_DELIVERED : OUT_RX_DISCARDED;
                cmd_next.frame_length = rx_good ? (s_desc_byte_count - CRC_BYTES) : 12'd0;
                cmd_next.length_word = {LENGTH_TOP, RX_NEG_LEN};
                cmd_next.status_word = RX_STATUS_WORD;
                cmd_next.write_back  = 1'b1;
            end
        end else if (tx_bad) begin
            cmd_next.outcome = OUT_TX_REJECTED;
        end else if (s_desc_status[OWN_POS]) begin
            cmd_next.outcome = OUT_TX_FULL;
        end else begin
            cmd_next.outcome      = OUT_TX_QUEUED;
            cmd_next.frame_length = tx_total[11:0];
            cmd_next.pad_bytes    = 6'(tx_total - s_send_length);
            cmd_next.length_word  = {LENGTH_TOP, 12'(12'd0 - tx_total[11:0])};
            cmd_next.status_word  = TX_STATUS_WORD;
            cmd_next.write_back   = 1'b1;
        end

        enabled_next = (cfg_valid && cfg_ready) ? cfg_enabled : enabled_reg;
        if (s_valid && s_ready) begin
            cmd_valid_next = 1'b1;
        end else if (cmd_ready) begin
            cmd_valid_next = 1'b0;
        end else begin
            cmd_valid_next = cmd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg   <= 1'b0;
            cmd_valid_reg <= 1'b0;
        end else begin
            enabled_reg   <= enabled_next;
            cmd_valid_reg <= cmd_valid_next;
        end
        if (s_valid && s_ready) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// ===== design/edr_queue.sv =====
// two-entry command queue between front and back end
// depends on edr_pkg
module edr_queue import edr_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    cmd_t mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;
    logic push, pop;

    assign in_ready  = count_reg != (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_cmd   = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_PTR_W+1)'(push) - (QUEUE_PTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== design/edr_back.sv =====
// back end: ring indices, frame counters and the result register
// depends on edr_pkg
module edr_back import edr_pkg::*; #(
    parameter int unsigned RX_RING_LOG = 6,
    parameter int unsigned TX_RING_LOG = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_outcome,
    output logic [5:0]  m_ring_index,
    output logic [11:0] m_frame_length,
    output logic [5:0]  m_pad_bytes,
    output logic [15:0] m_length_word,
    output logic [15:0] m_status_word,
    output logic        m_write_back,
    output logic [31:0] m_rx_frames,
    output logic [31:0] m_tx_frames
);

    logic [RX_RING_LOG-1:0] rx_index_reg, rx_index_next;
    logic [TX_RING_LOG-1:0] tx_index_reg, tx_index_next;
    logic [31:0] rx_count_reg, rx_count_next;
    logic [31:0] tx_count_reg, tx_count_next;
    logic        m_valid_reg, m_valid_next;
    cmd_t        res_reg;
    logic [5:0]  idx_reg, idx_next;
    logic        take, is_rx, rx_adv, tx_adv;

    assign cmd_ready = !m_valid_reg || m_ready;
    assign take      = cmd_valid && cmd_ready;

    always_comb begin
        is_rx  = (cmd.outcome == OUT_RX_EMPTY) || (cmd.outcome == OUT_RX_DELIVERED)
                 || (cmd.outcome == OUT_RX_DISCARDED);
        rx_adv = take && ((cmd.outcome == OUT_RX_DELIVERED) || (cmd.outcome == OUT_RX_DISCARDED));
        tx_adv = take && (cmd.outcome == OUT_TX_QUEUED);
        idx_next      = is_rx ? 6'(rx_index_reg) : 6'(tx_index_reg);
        rx_index_next = rx_adv ? rx_index_reg + 1'b1 : rx_index_reg;
        tx_index_next = tx_adv ? tx_index_reg + 1'b1 : tx_index_reg;
        rx_count_next = (take && cmd.outcome == OUT_RX_DELIVERED) ? rx_count_reg + 32'd1
                                                                  : rx_count_reg;
        tx_count_next = tx_adv ? tx_count_reg + 32'd1 : tx_count_reg;
        if (take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_index_reg <= '0;
            tx_index_reg <= '0;
            rx_count_reg <= '0;
            tx_count_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            rx_index_reg <= rx_index_next;
            tx_index_reg <= tx_index_next;
            rx_count_reg <= rx_count_next;
            tx_count_reg <= tx_count_next;
            m_valid_reg  <= m_valid_next;
        end
        if (take) begin
            res_reg <= cmd;
            idx_reg <= idx_next;
        end
    end

    // counters shown as they stand after the beat in the result register
    logic [31:0] rx_shown_reg, tx_shown_reg;
    always_ff @(posedge aclk) begin
        if (take) begin
            rx_shown_reg <= rx_count_next;
            tx_shown_reg <= tx_count_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_outcome      = res_reg.outcome;
    assign m_ring_index   = idx_reg;
    assign m_frame_length = res_reg.frame_length;
    assign m_pad_bytes    = res_reg.pad_bytes;
    assign m_length_word  = res_reg.length_word;
    assign m_status_word  = res_reg.status_word;
    assign m_write_back   = res_reg.write_back;
    assign m_rx_frames    = rx_shown_reg;
    assign m_tx_frames    = tx_shown_reg;

endmodule

// ===== design/ethernet_descriptor_ring_host.sv =====
// top level of the host-side descriptor ring handler
// depends on edr_pkg, edr_front, edr_queue, edr_back
//
// usage:
//   s_ channel: one request beat per descriptor; s_req_type 0 examines the
//   receive descriptor at the current rx index, 1 asks to send s_send_length
//   bytes using the descriptor at the current tx index
//   m_ channel: one result beat per request, in request order, giving the
//   outcome, the index acted on, the descriptor words to write back and the
//   frame counters after this request
//   cfg_ channel: writes the enabled flag; always ready, write only when idle
// path: the front classify register loads at the accept edge; the command
//   queue and then the result register each hold the request in turn
// throughput: one request per cycle sustained while m_ready stays high
// reset: aresetn low clears both ring indices, both counters and the enabled
//   flag; the user sends no request until aresetn is high again (unenforced)
// stall: when m_ready is low the result holds, the queue fills, and after
//   that s_ready drops; nothing is lost
module ethernet_descriptor_ring_host import edr_pkg::*; #(
    parameter int unsigned RX_RING_LOG     = 6,
    parameter int unsigned TX_RING_LOG     = 4,
    parameter int unsigned BUFFER_BYTES    = 2048,
    parameter int unsigned MIN_FRAME_BYTES = 60
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_enabled,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [15:0] s_desc_status,
    input  logic [11:0] s_desc_byte_count,
    input  logic [15:0] s_send_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_outcome,
    output logic [5:0]  m_ring_index,
    output logic [11:0] m_frame_length,
    output logic [5:0]  m_pad_bytes,
    output logic [15:0] m_length_word,
    output logic [15:0] m_status_word,
    output logic        m_write_back,
    output logic [31:0] m_rx_frames,
    output logic [31:0] m_tx_frames
);

    logic fq_valid, fq_ready, qb_valid, qb_ready;
    cmd_t fq_cmd, qb_cmd;

    edr_front #(
        .BUFFER_BYTES    (BUFFER_BYTES),
        .MIN_FRAME_BYTES (MIN_FRAME_BYTES)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_enabled       (cfg_enabled),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_desc_status     (s_desc_status),
        .s_desc_byte_count (s_desc_byte_count),
        .s_send_length     (s_send_length),
        .cmd_valid         (fq_valid),
        .cmd_ready         (fq_ready),
        .cmd               (fq_cmd)
    );

    edr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_cmd   (qb_cmd)
    );

    edr_back #(
        .RX_RING_LOG (RX_RING_LOG),
        .TX_RING_LOG (TX_RING_LOG)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd_valid      (qb_valid),
        .cmd_ready      (qb_ready),
        .cmd            (qb_cmd),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_outcome      (m_outcome),
        .m_ring_index   (m_ring_index),
        .m_frame_length (m_frame_length),
        .m_pad_bytes    (m_pad_bytes),
        .m_length_word  (m_length_word),
        .m_status_word  (m_status_word),
        .m_write_back   (m_write_back),
        .m_rx_frames    (m_rx_frames),
        .m_tx_frames    (m_tx_frames)
    );

    // write-back only when a descriptor is returned or queued
    a_write_back: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_write_back == ((m_outcome == OUT_RX_DELIVERED)
            || (m_outcome == OUT_RX_DISCARDED) || (m_outcome == OUT_TX_QUEUED))))
        else $error("write-back flag disagrees with outcome");

    // padding only on queued sends
    a_pad_only_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_pad_bytes != 6'd0)) |-> (m_outcome == OUT_TX_QUEUED))
        else $error("padding on a result that is not a queued send");

    // length word is the negated frame length on a queued send
    a_tx_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_outcome == OUT_TX_QUEUED))
            |-> (12'(m_frame_length + m_length_word[11:0]) == 12'd0))
        else $error("length word does not negate frame length");

    // the front holds its command while the command queue is full
    a_queue_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (fq_valid && !fq_ready) |=> fq_valid)
        else $error("front command lost while queue full");

endmodule

// ===== sim/ring_host_check_pkg.sv =====
// expected-result scoreboard for the descriptor ring host testbench
// depends on edr_pkg for the outcome codes, status bit positions and descriptor words
package ring_host_check_pkg;
    import edr_pkg::*;

    localparam int unsigned RX_RING_LOG     = 6;
    localparam int unsigned TX_RING_LOG     = 4;
    localparam int unsigned BUFFER_BYTES    = 2048;
    localparam int unsigned MIN_FRAME_BYTES = 60;

    typedef struct {
        outcome_t    outcome;
        logic [5:0]  ring_index;
        logic [11:0] frame_length;
        logic [5:0]  pad_bytes;
        logic [15:0] length_word;
        logic [15:0] status_word;
        logic        write_back;
        logic [31:0] rx_frames;
        logic [31:0] tx_frames;
    } ring_result_t;

    class ring_host_scoreboard;
        bit                     enabled      = 1'b0;
        logic [RX_RING_LOG-1:0] rx_index     = '0;
        logic [TX_RING_LOG-1:0] tx_index     = '0;
        logic [31:0]            rx_delivered = '0;
        logic [31:0]            tx_queued    = '0;
        ring_result_t           awaited_results[$];
        int unsigned            mismatches   = 0;
        int unsigned            results_seen = 0;
        int unsigned            outcome_count[6];

        function void set_enabled(bit value);
            enabled = value;
        endfunction

        function logic [15:0] negated_length_word(logic [11:0] len);
            return {LENGTH_TOP, 12'd0 - len};
        endfunction

        function void note_request(logic req_type, logic [15:0] status,
                                   logic [11:0] byte_count, logic [15:0] send_length);
            ring_result_t want;
            int unsigned  total;
            want.outcome      = OUT_RX_EMPTY;
            want.frame_length = '0;
            want.pad_bytes    = '0;
            want.length_word  = '0;
            want.status_word  = '0;
            want.write_back   = 1'b0;
            if (!req_type) begin
                want.ring_index = 6'(rx_index);
                if (!status[OWN_POS]) begin
                    if (status[START_POS] && status[END_POS] && !status[ERR_POS] &&
                        byte_count > CRC_BYTES && byte_count <= BUFFER_BYTES) begin
                        want.outcome      = OUT_RX_DELIVERED;
                        want.frame_length = byte_count - CRC_BYTES;
                        rx_delivered++;
                    end else begin
                        want.outcome = OUT_RX_DISCARDED;
                    end
                    want.length_word = negated_length_word(12'(BUFFER_BYTES));
                    want.status_word = RX_STATUS_WORD;
                    want.write_back  = 1'b1;
                    rx_index++;
                end
            end else begin
                want.ring_index = 6'(tx_index);
                if (!enabled || send_length == 0 || send_length > BUFFER_BYTES) begin
                    want.outcome = OUT_TX_REJECTED;
                end else if (status[OWN_POS]) begin
                    want.outcome = OUT_TX_FULL;
                end else begin
                    total = (send_length < MIN_FRAME_BYTES) ? MIN_FRAME_BYTES : send_length;
                    want.outcome      = OUT_TX_QUEUED;
                    want.frame_length = 12'(total);
                    want.pad_bytes    = 6'(total - send_length);
                    want.length_word  = negated_length_word(12'(total));
                    want.status_word  = TX_STATUS_WORD;
                    want.write_back   = 1'b1;
                    tx_index++;
                    tx_queued++;
                end
            end
            want.rx_frames = rx_delivered;
            want.tx_frames = tx_queued;
            awaited_results.push_back(want);
        endfunction

        function void compare_field(string field, logic [31:0] expected, logic [31:0] actual);
            if (actual !== expected) begin
                $error("%s: expected %0h, got %0h", field, expected, actual);
                mismatches++;
            end
        endfunction

        function void check_result(ring_result_t got);
            ring_result_t want;
            results_seen++;
            if (awaited_results.size() == 0) begin
                $error("result beat with nothing expected, outcome %0d", got.outcome);
                mismatches++;
                return;
            end
            want = awaited_results.pop_front();
            outcome_count[want.outcome]++;
            compare_field("outcome", want.outcome, got.outcome);
            compare_field("ring_index", want.ring_index, got.ring_index);
            compare_field("frame_length", want.frame_length, got.frame_length);
            compare_field("pad_bytes", want.pad_bytes, got.pad_bytes);
            compare_field("length_word", want.length_word, got.length_word);
            compare_field("status_word", want.status_word, got.status_word);
            compare_field("write_back", want.write_back, got.write_back);
            compare_field("rx_frames", want.rx_frames, got.rx_frames);
            compare_field("tx_frames", want.tx_frames, got.tx_frames);
        endfunction
    endclass

endpackage

// ===== sim/tb_ethernet_descriptor_ring_host.sv =====
// testbench top for the descriptor ring host: directed and random rx/tx beats
// under several idle profiles, checked against ring_host_check_pkg
// depends on edr_pkg, ring_host_check_pkg and the ethernet_descriptor_ring_host rtl
module tb_ethernet_descriptor_ring_host;
    timeunit 1ns;
    timeprecision 1ps;
    import edr_pkg::*;
    import ring_host_check_pkg::*;

    localparam logic        REQ_RX         = 1'b0;
    localparam logic        REQ_TX         = 1'b1;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned HOLD_CYCLES    = 60;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned PHASES         = 4;
    localparam int unsigned PHASE_ITEMS[PHASES]     = '{150, 100, 150, 100};
    localparam int unsigned PHASE_SEND_IDLE[PHASES] = '{0, 73, 0, 13};
    localparam int unsigned PHASE_RECV_IDLE[PHASES] = '{0, 0, 73, 13};
    localparam bit          PHASE_ENABLED[PHASES]   = '{1'b1, 1'b0, 1'b1, 1'b1};

    logic        aclk              = 1'b0;
    logic        aresetn           = 1'b0;
    logic        cfg_valid         = 1'b0;
    logic        cfg_ready;
    logic        cfg_enabled       = 1'b0;
    logic        s_valid           = 1'b0;
    logic        s_ready;
    logic        s_req_type        = 1'b0;
    logic [15:0] s_desc_status     = '0;
    logic [11:0] s_desc_byte_count = '0;
    logic [15:0] s_send_length     = '0;
    logic        m_valid;
    logic        m_ready           = 1'b0;
    logic [2:0]  m_outcome;
    logic [5:0]  m_ring_index;
    logic [11:0] m_frame_length;
    logic [5:0]  m_pad_bytes;
    logic [15:0] m_length_word;
    logic [15:0] m_status_word;
    logic        m_write_back;
    logic [31:0] m_rx_frames;
    logic [31:0] m_tx_frames;

    ring_host_scoreboard sb;
    int unsigned         sender_idle_pct    = 0;
    int unsigned         receiver_stall_pct = 0;
    int unsigned         requests_sent      = 0;
    int unsigned         stalled_cycles     = 0;
    int unsigned         hold_left          = 0;
    bit                  hold_req           = 1'b0;

    ethernet_descriptor_ring_host #(
        .RX_RING_LOG    (RX_RING_LOG),
        .TX_RING_LOG    (TX_RING_LOG),
        .BUFFER_BYTES   (BUFFER_BYTES),
        .MIN_FRAME_BYTES(MIN_FRAME_BYTES)
    ) dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic send_request(input logic req, input logic [15:0] status,
                                input logic [11:0] byte_count, input logic [15:0] len);
        s_valid           <= 1'b1;
        s_req_type        <= req;
        s_desc_status     <= status;
        s_desc_byte_count <= byte_count;
        s_send_length     <= len;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        requests_sent++;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic write_enabled(input logic value);
        cfg_valid   <= 1'b1;
        cfg_enabled <= value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        sb.set_enabled(value);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.results_seen < requests_sent) @(posedge aclk);
    endtask

    // receiver side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // beat monitor and watchdog
    always @(posedge aclk) begin
        ring_result_t got;
        if (aresetn && s_valid && s_ready)
            sb.note_request(s_req_type, s_desc_status, s_desc_byte_count, s_send_length);
        if (aresetn && m_valid && m_ready) begin
            got.outcome      = outcome_t'(m_outcome);
            got.ring_index   = m_ring_index;
            got.frame_length = m_frame_length;
            got.pad_bytes    = m_pad_bytes;
            got.length_word  = m_length_word;
            got.status_word  = m_status_word;
            got.write_back   = m_write_back;
            got.rx_frames    = m_rx_frames;
            got.tx_frames    = m_tx_frames;
            sb.check_result(got);
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("ethernet_descriptor_ring_host test failed");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    initial begin
        logic        req;
        logic [15:0] status;
        logic [11:0] byte_count;
        logic [15:0] len;
        int unsigned pick;
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // disabled interface rejects sends
        write_enabled(1'b0);
        send_request(REQ_TX, 16'h0000, 12'($urandom), 16'd100);
        drain_results();
        write_enabled(1'b1);

        // receive: card owned, length limits, error and fragment bits
        send_request(REQ_RX, 16'h8000, 12'd100, 16'($urandom));
        send_request(REQ_RX, 16'hFFFF, 12'hFFF, 16'($urandom));
        send_request(REQ_RX, 16'h0300, 12'd0, 16'($urandom));
        send_request(REQ_RX, 16'h0300, 12'd4, 16'($urandom));
        send_request(REQ_RX, 16'h0300, 12'd5, 16'($urandom));
        send_request(REQ_RX, 16'h0300, 12'(BUFFER_BYTES), 16'($urandom));
        send_request(REQ_RX, 16'h0300, 12'(BUFFER_BYTES + 1), 16'($urandom));
        send_request(REQ_RX, 16'h0300, 12'hFFF, 16'($urandom));
        send_request(REQ_RX, 16'h4300, 12'd100, 16'($urandom));
        send_request(REQ_RX, 16'h0200, 12'd100, 16'($urandom));
        send_request(REQ_RX, 16'h0100, 12'd100, 16'($urandom));
        send_request(REQ_RX, 16'h0000, 12'd100, 16'($urandom));
        send_request(REQ_RX, 16'h7FFF, 12'd64, 16'($urandom));
        send_request(REQ_RX, 16'h03FF, 12'd64, 16'($urandom));
        // transmit: length limits, padding edges, ring full
        send_request(REQ_TX, 16'h0000, 12'($urandom), 16'd0);
        send_request(REQ_TX, 16'h0000, 12'($urandom), 16'd1);
        send_request(REQ_TX, 16'h0000, 12'($urandom), 16'(MIN_FRAME_BYTES - 1));
        send_request(REQ_TX, 16'h0000, 12'($urandom), 16'(MIN_FRAME_BYTES));
        send_request(REQ_TX, 16'h0000, 12'($urandom), 16'(MIN_FRAME_BYTES + 1));
        send_request(REQ_TX, 16'h0000, 12'($urandom), 16'(BUFFER_BYTES));
        send_request(REQ_TX, 16'h0000, 12'($urandom), 16'(BUFFER_BYTES + 1));
        send_request(REQ_TX, 16'h0000, 12'($urandom), 16'hFFFF);
        send_request(REQ_TX, 16'h8000, 12'($urandom), 16'd100);
        send_request(REQ_TX, 16'hFFFF, 12'($urandom), 16'd0);
        send_request(REQ_TX, 16'h7FFF, 12'($urandom), 16'd100);

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            write_enabled(PHASE_ENABLED[p]);
            sender_idle_pct    = PHASE_SEND_IDLE[p];
            receiver_stall_pct = PHASE_RECV_IDLE[p];
            for (int i = 0; i < PHASE_ITEMS[p]; i++) begin
                if (p == 0 && i == 40)
                    hold_req = 1'b1;
                req        = 1'($urandom_range(1));
                status     = 16'($urandom);
                byte_count = 12'($urandom);
                len        = 16'($urandom);
                pick       = $urandom_range(99);
                if (req == REQ_RX) begin
                    if (pick < 20) begin
                        status[OWN_POS] = 1'b1;
                    end else if (pick < 80) begin
                        status[OWN_POS]   = 1'b0;
                        status[ERR_POS]   = 1'b0;
                        status[START_POS] = 1'b1;
                        status[END_POS]   = 1'b1;
                    end else begin
                        status[OWN_POS] = 1'b0;
                    end
                    pick = $urandom_range(99);
                    if (pick < 70)
                        byte_count = 12'($urandom_range(BUFFER_BYTES, 5));
                    else if (pick < 80)
                        byte_count = 12'($urandom_range(4, 0));
                    else if (pick < 85)
                        byte_count = 12'($urandom_range(BUFFER_BYTES + 2, BUFFER_BYTES - 2));
                end else begin
                    status[OWN_POS] = (pick < 15);
                    pick = $urandom_range(99);
                    if (pick < 70)
                        len = 16'($urandom_range(BUFFER_BYTES, 1));
                    else if (pick < 82)
                        len = 16'($urandom_range(MIN_FRAME_BYTES + 1, 1));
                    else if (pick < 87)
                        len = 16'd0;
                    else if (pick < 92)
                        len = 16'($urandom_range(BUFFER_BYTES + 2, BUFFER_BYTES - 2));
                end
                send_request(req, status, byte_count, len);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.awaited_results.size() != 0) begin
            $error("%0d expected results never arrived", sb.awaited_results.size());
            sb.mismatches++;
        end
        $display("covered %0d beats: rx empty %0d, delivered %0d, discarded %0d",
                 requests_sent, sb.outcome_count[OUT_RX_EMPTY],
                 sb.outcome_count[OUT_RX_DELIVERED], sb.outcome_count[OUT_RX_DISCARDED]);
        $display("tx queued %0d, rejected %0d, ring full %0d; idle profiles and long stall done",
                 sb.outcome_count[OUT_TX_QUEUED], sb.outcome_count[OUT_TX_REJECTED],
                 sb.outcome_count[OUT_TX_FULL]);
        if (sb.mismatches == 0) begin
            $display("ethernet_descriptor_ring_host test passed");
        end else begin
            $display("ethernet_descriptor_ring_host test failed");
        end
        $finish;
    end

endmodule

// ===== ethernet_descriptor_ring_host.f =====
design/edr_pkg.sv
design/edr_front.sv
design/edr_queue.sv
design/edr_back.sv
design/ethernet_descriptor_ring_host.sv
sim/ring_host_check_pkg.sv
sim/tb_ethernet_descriptor_ring_host.sv
